// ----- hdl/unsigned_to_ascii_radix_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned_to_ascii_radix_core block
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_RADIX_CORE_MACROS_SVH
`define UNSIGNED_TO_ASCII_RADIX_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define UTAR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define UTAR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define UTAR_ASSERT_ALWAYS(lbl, cond, msg)
`define UTAR_ASSERT_IMPL(lbl, ante, cons, msg)
`define UTAR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/utar_pkg.sv -----
// ----------------------------------------------------------------------------
// utar_pkg
// Types, codes and helper functions shared by the radix conversion block.
// ----------------------------------------------------------------------------
package utar_pkg;

  localparam int VALUE_W     = 16;
  localparam int CAP_W       = 8;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = DIGIT_W + 1;
  localparam int NUM_CELLS   = VALUE_W;
  localparam int CELL_IDX_W  = $clog2(NUM_CELLS);
  localparam int CNT_W       = $clog2(NUM_CELLS + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  // Radix selector codes.
  localparam logic [1:0] MODE_BIN = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;
  localparam logic [1:0] MODE_BAD = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ARG   = 2'd1;
  localparam logic [1:0] STATUS_TOO_SMALL = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         mode;
    logic [CAP_W-1:0]   capacity;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic [1:0]        status;
    logic              last;
  } result_t;

  // Control from the sequencer to the row of cells.
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic [1:0] mode;
    logic       bit_in;
  } chain_ctrl_t;

  // Status from the row of cells back to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] ndigits;
    logic             overflow;
  } chain_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CHECK,
    S_EMIT,
    S_BAD,
    S_SMALL
  } state_t;

  function automatic logic [RADIX_W-1:0] radix_of(logic [1:0] mode);
    logic [RADIX_W-1:0] r;
    case (mode)
      MODE_BIN: r = RADIX_W'(2);
      MODE_DEC: r = RADIX_W'(10);
      default:  r = RADIX_W'(16);
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(digit_t d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

// ----- hdl/utar_cell.sv -----
// ----------------------------------------------------------------------------
// utar_cell
// One digit of the conversion row: doubles its digit and adds the bit from
// its lower neighbour, passing a carry up when the doubled digit reaches the radix.
// ----------------------------------------------------------------------------
module utar_cell import utar_pkg::*; (
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  logic        carry_in,
  output digit_t      digit,
  output logic        carry_out
);

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] doubled;
  logic [RADIX_W-1:0] reduced;
  digit_t             digit_next;

  // For an even radix the carry depends only on the stored digit, so no
  // carry ripples along the row.
  assign radix      = radix_of(ctrl.mode);
  assign carry_out  = {1'b0, digit} >= (radix >> 1);
  assign doubled    = {digit, carry_in};
  assign reduced    = carry_out ? (doubled - radix) : doubled;
  assign digit_next = reduced[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= digit_next;
    end
  end

endmodule

// ----- hdl/utar_chain.sv -----
// ----------------------------------------------------------------------------
// utar_chain
// Row of digit cells with the leading-digit count over the row.
// ----------------------------------------------------------------------------
module utar_chain import utar_pkg::*; (
  input  logic                        clk,
  input  chain_ctrl_t                 ctrl,
  output digit_t [NUM_CELLS-1:0]      digits,
  output chain_stat_t                 stat
);

  logic [NUM_CELLS-1:0] carry;
  logic [CNT_W-1:0]     ndigits;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic cin;
    if (g == 0) begin : g_first
      assign cin = ctrl.bit_in;
    end else begin : g_rest
      assign cin = carry[g-1];
    end
    utar_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (cin),
      .digit     (digits[g]),
      .carry_out (carry[g])
    );
  end

  // Position of the highest non-zero digit; zero still shows one digit.
  always_comb begin
    ndigits = CNT_W'(1);
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (digits[i] != '0) begin
        ndigits = CNT_W'(i + 1);
      end
    end
  end

  assign stat.ndigits  = ndigits;
  assign stat.overflow = ctrl.shift & carry[NUM_CELLS-1];

endmodule

// ----- hdl/unsigned_to_ascii_radix_core.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_core
// Converts a 16-bit unsigned value to ASCII digits in base 2, 10 or 16,
// most significant digit first, followed by a terminating NUL.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload   Handshake
//   item     in         item_t    item_valid / item_stall
//   result   out        result_t  result_valid / result_stall
//
// An item is taken in the idle state and then occupies the block on its own:
// the value is shifted into the row of digit cells one bit a cycle, the
// check state counts the digits, and then one result is offered per cycle
// while the result channel does not stall. An invalid radix or a zero
// capacity is reported straight from idle, without conversion; a buffer that
// is too small is reported only after the digits have been counted.
// Reset returns the sequencer to idle and empties the output register.
// A stall on the result channel holds the output register and pauses the
// emission; the next item is taken once the final result is in the register.
//
`include "unsigned_to_ascii_radix_core_macros.svh"

module unsigned_to_ascii_radix_core import utar_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  state_t                  state;
  state_t                  state_next;
  logic [VALUE_W-1:0]      shreg;
  logic [1:0]              radix_mode;
  logic [CAP_W-1:0]        cap;
  logic [BIT_CNT_W-1:0]    bit_cnt;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        idx_m1;

  chain_ctrl_t             ctrl;
  chain_stat_t             stat;
  digit_t [NUM_CELLS-1:0]  digits;

  logic                    item_take;
  logic                    load_ok;
  logic                    load;
  result_t                 push_data;
  logic                    too_small;
  logic                    last_bit;

  // The row of cells does the radix conversion; the sequencer below only
  // feeds it bits and reads the finished digits out.
  utar_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .digits (digits),
    .stat   (stat)
  );

  assign item_take = item_valid & ~item_stall;
  // The output register can take a new result when empty or being drained.
  assign load_ok   = ~result_valid | ~result_stall;
  assign idx_m1    = idx - CNT_W'(1);
  assign last_bit  = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
  // The string needs one place per digit plus one for the NUL.
  assign too_small = (CAP_W'(stat.ndigits) + CAP_W'(1)) > cap;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if ((item.mode == MODE_BAD) || (item.capacity == '0)) begin
            state_next = S_BAD;
          end else begin
            state_next = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (last_bit) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = too_small ? S_SMALL : S_EMIT;
      end
      S_EMIT: begin
        if (load_ok && (idx == '0)) begin
          state_next = S_IDLE;
        end
      end
      S_BAD, S_SMALL: begin
        if (load_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    item_stall  = 1'b1;
    load        = 1'b0;
    push_data   = '{character: CHAR_NUL, status: STATUS_OK, last: 1'b1};
    ctrl.clear  = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.mode   = radix_mode;
    ctrl.bit_in = shreg[VALUE_W-1];
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        ctrl.clear = item_valid;
      end
      S_CONV: begin
        ctrl.shift = 1'b1;
      end
      S_CHECK: begin
      end
      S_EMIT: begin
        load = load_ok;
        if (idx != '0) begin
          push_data = '{character: to_ascii(digits[idx_m1[CELL_IDX_W-1:0]]),
                        status: STATUS_OK, last: 1'b0};
        end
      end
      S_BAD: begin
        load      = load_ok;
        push_data = '{character: CHAR_NUL, status: STATUS_BAD_ARG, last: 1'b1};
      end
      S_SMALL: begin
        load      = load_ok;
        push_data = '{character: CHAR_NUL, status: STATUS_TOO_SMALL, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      result <= push_data;
    end
    if (item_take) begin
      shreg      <= item.value;
      radix_mode <= item.mode;
      cap        <= item.capacity;
      bit_cnt    <= '0;
    end else if (ctrl.shift) begin
      shreg   <= shreg << 1;
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (state == S_CHECK) begin
      idx <= stat.ndigits;
    end else if (load && (state == S_EMIT) && (idx != '0)) begin
      idx <= idx_m1;
    end
  end

  // A 16-bit value always fits the row, so the top cell never carries out.
  `UTAR_ASSERT_ALWAYS(a_no_overflow, !stat.overflow, "digit row overflowed")
  // A transfer on the item channel always starts work.
  `UTAR_ASSERT_NEXT(a_take_busy, item_take, state != S_IDLE, "item taken but sequencer idle")
  // Error results carry a NUL and close the conversion.
  `UTAR_ASSERT_IMPL(a_err_shape, result_valid && (result.status != STATUS_OK), (result.character == CHAR_NUL) && result.last, "malformed error result")

endmodule
